// ===== design/oss_pkg.sv =====
// Shared types, constants and table lookups for the oscillator setting solver.
// No dependencies; every module of the block imports this package.
package oss_pkg;

	// Field widths
	localparam int unsigned FREQ_W = 32;
	localparam int unsigned EXP_W  = 4;
	localparam int unsigned IDX_W  = 4;
	localparam int unsigned OFS_W  = 8;
	localparam int unsigned DAC_W  = 10;
	localparam int unsigned BASE_W = 5;

	// Configuration port
	localparam int unsigned PADDR_W = 5;
	localparam int unsigned PDATA_W = 32;

	typedef enum logic [2:0] {
		REG_RANGE_BASE = 3'd0,
		REG_FREQ_LOW   = 3'd1,
		REG_FREQ_HIGH  = 3'd2,
		REG_OSC_LOW    = 3'd3,
		REG_OSC_HIGH   = 3'd4
	} reg_idx_t;

	localparam logic [BASE_W-1:0] RANGE_BASE_RST = '0;
	localparam logic [FREQ_W-1:0] FREQ_LOW_RST   = 32'd130000;
	localparam logic [FREQ_W-1:0] FREQ_HIGH_RST  = 32'd66600000;
	localparam logic [FREQ_W-1:0] OSC_LOW_RST    = 32'd33300000;
	localparam logic [FREQ_W-1:0] OSC_HIGH_RST   = 32'd66600000;

	// Prescaler search
	localparam int unsigned MAX_EXP = 9;

	// Range table
	localparam int unsigned NUM_ENTRIES = 13;
	localparam logic [IDX_W-1:0] DEFAULT_ENTRY = 4'd6;
	localparam logic [FREQ_W-1:0] RANGE_WIDTH = 32'd5120000;
	localparam logic [FREQ_W-1:0] RANGE_HALF  = RANGE_WIDTH / 2;
	localparam int unsigned DIST_W = $clog2(RANGE_HALF + 1);

	// DAC step and its reciprocal: q ~= (x * DIV_MULT) >> DIV_SHIFT, at most one low
	localparam int unsigned DAC_STEP  = 5000;
	localparam int unsigned DIV_SHIFT = 31 + $clog2(DAC_STEP);
	localparam logic [63:0] DIV_MULT_FULL = (64'd1 << DIV_SHIFT) / 64'(DAC_STEP);
	localparam logic [FREQ_W-1:0] DIV_MULT = DIV_MULT_FULL[FREQ_W-1:0];
	localparam logic [FREQ_W-1:0] STEP_VAL = FREQ_W'(DAC_STEP);

	// Pipeline depth
	localparam int unsigned NUM_STAGES = 7;

	typedef struct packed {
		logic [BASE_W-1:0] range_base;
		logic [FREQ_W-1:0] freq_low;
		logic [FREQ_W-1:0] freq_high;
		logic [FREQ_W-1:0] osc_low;
		logic [FREQ_W-1:0] osc_high;
	} cfg_t;

	typedef struct packed {
		logic [NUM_STAGES-1:0] en;
		logic [NUM_STAGES-1:0] vld;
	} pipe_ctl_t;

	typedef struct packed {
		logic             accepted;
		logic [EXP_W-1:0] exp;
		logic [IDX_W-1:0] idx;
		logic [OFS_W-1:0] offset;
	} res_meta_t;

	typedef struct packed {
		logic              hit;
		logic [IDX_W-1:0]  idx;
		logic [DIST_W-1:0] gap;
	} cand_t;

	// Lower bound of each range table entry
	function automatic logic [FREQ_W-1:0] entry_min(input logic [IDX_W-1:0] idx);
		logic [FREQ_W-1:0] v;
		case (idx)
			4'd0:    v = 32'd30740000;
			4'd1:    v = 32'd33300000;
			4'd2:    v = 32'd35860000;
			4'd3:    v = 32'd38420000;
			4'd4:    v = 32'd40980000;
			4'd5:    v = 32'd43540000;
			4'd6:    v = 32'd46100000;
			4'd7:    v = 32'd48660000;
			4'd8:    v = 32'd51220000;
			4'd9:    v = 32'd53780000;
			4'd10:   v = 32'd56340000;
			4'd11:   v = 32'd58900000;
			4'd12:   v = 32'd61460000;
			default: v = 32'd46100000;
		endcase
		return v;
	endfunction

	// Keep the closer candidate; a is the lower index and wins ties
	function automatic cand_t pick_closer(input cand_t a, input cand_t b);
		cand_t w;
		if (a.hit && (!b.hit || a.gap <= b.gap)) begin
			w = a;
		end else if (b.hit) begin
			w = b;
		end else begin
			w = a;
		end
		return w;
	endfunction

endpackage

// ===== design/oss_exp_stage.sv =====
// Stage 1: request window check and prescaler exponent search.
// Depends on oss_pkg.
module oss_exp_stage (
	input  logic                      clk,
	input  oss_pkg::pipe_ctl_t        ctl,
	input  oss_pkg::cfg_t             cfg,
	input  logic [oss_pkg::FREQ_W-1:0] target_freq,
	output logic                      accepted_s1,
	output logic [oss_pkg::EXP_W-1:0]  exp_s1,
	output logic [oss_pkg::FREQ_W-1:0] osc_s1
);
	import oss_pkg::*;

	logic [FREQ_W-1:0] shifted [MAX_EXP];
	logic [MAX_EXP-1:0] fit;
	logic [EXP_W-1:0]  sel_exp;
	logic [FREQ_W-1:0] sel_osc;
	logic              in_window;

	// Shift by each exponent and test against the oscillator window
	always_comb begin
		for (int e = 0; e < MAX_EXP; e++) begin
			shifted[e] = target_freq << e;
			fit[e] = (shifted[e] > cfg.osc_low) && (shifted[e] < cfg.osc_high);
		end
	end

	// Take the first exponent that fits, else fall back to the largest shift
	always_comb begin
		sel_exp = EXP_W'(MAX_EXP);
		sel_osc = shifted[MAX_EXP-1];
		for (int e = MAX_EXP - 1; e >= 0; e--) begin
			if (fit[e]) begin
				sel_exp = EXP_W'(e);
				sel_osc = shifted[e];
			end
		end
	end

	assign in_window = (target_freq >= cfg.freq_low) && (target_freq <= cfg.freq_high);

	always_ff @(posedge clk) begin
		if (ctl.en[0]) begin
			accepted_s1 <= in_window;
			exp_s1      <= sel_exp;
			osc_s1      <= sel_osc;
		end
	end

endmodule

// ===== design/oss_range_pick.sv =====
// Stages 2 to 4: range table match, closest-centre reduction, offset and DAC difference.
// Depends on oss_pkg.
module oss_range_pick (
	input  logic                        clk,
	input  logic                        arst_n,
	input  oss_pkg::pipe_ctl_t          ctl,
	input  logic [oss_pkg::BASE_W-1:0]   range_base,
	input  logic                        accepted_s1,
	input  logic [oss_pkg::EXP_W-1:0]    exp_s1,
	input  logic [oss_pkg::FREQ_W-1:0]   osc_s1,
	output oss_pkg::res_meta_t          meta_s4,
	output logic [oss_pkg::FREQ_W-1:0]   diff_s4
);
	import oss_pkg::*;

	cand_t             cand_d  [NUM_ENTRIES];
	cand_t             cand_s2 [NUM_ENTRIES];
	logic              acc_s2;
	logic [EXP_W-1:0]  exp_s2;
	logic [FREQ_W-1:0] osc_s2;

	cand_t             lvl1    [7];
	cand_t             lvl2    [4];
	cand_t             cand_s3 [4];
	logic              acc_s3;
	logic [EXP_W-1:0]  exp_s3;
	logic [FREQ_W-1:0] osc_s3;

	cand_t             half_a;
	cand_t             half_b;
	cand_t             winner;
	logic [IDX_W-1:0]  win_idx;
	res_meta_t         meta_d;
	logic [FREQ_W-1:0] diff_d;
	logic              hit_s4;
	logic [NUM_ENTRIES-1:0] hit_vec_s2;

	// Stage 2: containment and distance to centre for every entry
	always_comb begin
		logic [FREQ_W-1:0] lo;
		logic [FREQ_W-1:0] centre;
		logic [FREQ_W-1:0] gap;
		for (int i = 0; i < NUM_ENTRIES; i++) begin
			lo     = entry_min(IDX_W'(i));
			centre = lo + RANGE_HALF;
			gap    = (osc_s1 >= centre) ? (osc_s1 - centre) : (centre - osc_s1);
			cand_d[i].hit = (osc_s1 >= lo) && (osc_s1 <= lo + RANGE_WIDTH);
			cand_d[i].idx = IDX_W'(i);
			cand_d[i].gap = gap[DIST_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en[1]) begin
			cand_s2 <= cand_d;
			acc_s2  <= accepted_s1;
			exp_s2  <= exp_s1;
			osc_s2  <= osc_s1;
		end
	end

	// Stage 3: first two levels of the reduction tree
	always_comb begin
		for (int j = 0; j < 6; j++) begin
			lvl1[j] = pick_closer(cand_s2[2*j], cand_s2[2*j+1]);
		end
		lvl1[6] = cand_s2[NUM_ENTRIES-1];
		for (int j = 0; j < 3; j++) begin
			lvl2[j] = pick_closer(lvl1[2*j], lvl1[2*j+1]);
		end
		lvl2[3] = lvl1[6];
	end

	always_ff @(posedge clk) begin
		if (ctl.en[2]) begin
			cand_s3 <= lvl2;
			acc_s3  <= acc_s2;
			exp_s3  <= exp_s2;
			osc_s3  <= osc_s2;
		end
	end

	// Stage 4: final reduction, fallback entry, offset and distance above entry minimum
	always_comb begin
		half_a  = pick_closer(cand_s3[0], cand_s3[1]);
		half_b  = pick_closer(cand_s3[2], cand_s3[3]);
		winner  = pick_closer(half_a, half_b);
		win_idx = winner.hit ? winner.idx : DEFAULT_ENTRY;
		if (acc_s3) begin
			meta_d.accepted = 1'b1;
			meta_d.exp      = exp_s3;
			meta_d.idx      = win_idx;
			meta_d.offset   = OFS_W'(range_base) + OFS_W'(win_idx) - OFS_W'(DEFAULT_ENTRY);
			diff_d          = osc_s3 - entry_min(win_idx);
		end else begin
			meta_d = '0;
			diff_d = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en[3]) begin
			meta_s4 <= meta_d;
			diff_s4 <= diff_d;
			hit_s4  <= winner.hit;
		end
	end

	always_comb begin
		for (int i = 0; i < NUM_ENTRIES; i++) begin
			hit_vec_s2[i] = cand_s2[i].hit;
		end
	end

	// Overlapping ranges never hold a value in more than three entries
	a_hit_count: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.vld[1] |-> $countones(hit_vec_s2) <= 3)
		else $error("more than three range entries matched");

	// A matched entry leaves the value within its range width
	a_diff_range: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.vld[3] && meta_s4.accepted && hit_s4) |-> diff_s4 <= RANGE_WIDTH)
		else $error("difference outside the chosen range");

	// With no match the default entry is used
	a_fallback: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.vld[3] && meta_s4.accepted && !hit_s4) |-> meta_s4.idx == DEFAULT_ENTRY)
		else $error("fallback entry not used");

	// Rejected requests carry cleared fields
	a_reject_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.vld[3] && !meta_s4.accepted) |-> (meta_s4 == '0 && diff_s4 == '0))
		else $error("rejected request carries nonzero fields");

endmodule

// ===== design/oss_dac_div.sv =====
// Stages 5 to 7: division of the DAC difference by the step through a reciprocal
// multiply and one correction, plus the output register. Depends on oss_pkg.
module oss_dac_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  oss_pkg::pipe_ctl_t          ctl,
	input  oss_pkg::res_meta_t          meta_s4,
	input  logic [oss_pkg::FREQ_W-1:0]   diff_s4,
	output logic                        accepted,
	output logic [oss_pkg::EXP_W-1:0]    prescale_exp,
	output logic [oss_pkg::IDX_W-1:0]    table_index,
	output logic [oss_pkg::OFS_W-1:0]    offset_code,
	output logic [oss_pkg::DAC_W-1:0]    dac_code
);
	import oss_pkg::*;

	logic [2*FREQ_W-1:0] prod_s5;
	logic [FREQ_W-1:0]   diff_s5;
	res_meta_t           meta_s5;

	logic [2*FREQ_W-1:0] prod_sh;
	logic [FREQ_W-1:0]   q0_d;
	logic [FREQ_W-1:0]   qs_d;
	logic [FREQ_W-1:0]   q0_s6;
	logic [FREQ_W-1:0]   rem_s6;
	res_meta_t           meta_s6;

	logic [FREQ_W-1:0]   quot;
	res_meta_t           meta_s7;
	logic [DAC_W-1:0]    dac_s7;

	// Stage 5: reciprocal multiply
	always_ff @(posedge clk) begin
		if (ctl.en[4]) begin
			prod_s5 <= (2*FREQ_W)'(diff_s4) * (2*FREQ_W)'(DIV_MULT);
			diff_s5 <= diff_s4;
			meta_s5 <= meta_s4;
		end
	end

	// Stage 6: estimate quotient and its remainder
	always_comb begin
		prod_sh = prod_s5 >> DIV_SHIFT;
		q0_d    = prod_sh[FREQ_W-1:0];
		qs_d    = q0_d * STEP_VAL;
	end

	always_ff @(posedge clk) begin
		if (ctl.en[5]) begin
			q0_s6   <= q0_d;
			rem_s6  <= diff_s5 - qs_d;
			meta_s6 <= meta_s5;
		end
	end

	// Stage 7: correct an estimate that came out one low
	assign quot = (rem_s6 >= STEP_VAL) ? (q0_s6 + 1'b1) : q0_s6;

	always_ff @(posedge clk) begin
		if (ctl.en[6]) begin
			meta_s7 <= meta_s6;
			dac_s7  <= quot[DAC_W-1:0];
		end
	end

	assign accepted     = meta_s7.accepted;
	assign prescale_exp = meta_s7.exp;
	assign table_index  = meta_s7.idx;
	assign offset_code  = meta_s7.offset;
	assign dac_code     = dac_s7;

	// Reciprocal estimate is never more than one step low
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.vld[5] |-> ({1'b0, rem_s6} < ((FREQ_W+1)'(STEP_VAL) << 1)))
		else $error("quotient estimate off by more than one");

	// A cleared difference divides to zero
	a_reject_div: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.vld[5] && !meta_s6.accepted) |-> (q0_s6 == '0 && rem_s6 == '0))
		else $error("rejected request produced a nonzero quotient");

	// Rejected results show a zero DAC code
	a_reject_dac: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.vld[6] && !accepted) |-> dac_code == '0)
		else $error("rejected result with nonzero DAC code");

endmodule

// ===== design/oscillator_setting_solver.sv =====
// Oscillator setting solver: turns a requested frequency into prescaler exponent,
// range table entry, offset code and fine DAC code. One request enters per clock while
// in_ready is high and passes through a 7-stage pipeline (window check and
// exponent search, table match, two reduction stages, reciprocal multiply, remainder,
// correction); a stall on the output holds only the stages that are full, so bubbles
// close up and the input stays ready while any stage is free. Registers are written
// over an APB-style port at byte addresses 4*index and are meant to change only
// while the pipeline is empty. Depends on oss_pkg, oss_exp_stage, oss_range_pick,
// oss_dac_div.
module oscillator_setting_solver (
	input  logic                         clk,
	input  logic                         arst_n,
	// Request channel
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [oss_pkg::FREQ_W-1:0]    target_freq,
	// Result channel
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         accepted,
	output logic [oss_pkg::EXP_W-1:0]     prescale_exp,
	output logic [oss_pkg::IDX_W-1:0]     table_index,
	output logic [oss_pkg::OFS_W-1:0]     offset_code,
	output logic [oss_pkg::DAC_W-1:0]     dac_code,
	// Configuration port
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [oss_pkg::PADDR_W-1:0]   paddr,
	input  logic [oss_pkg::PDATA_W-1:0]   pwdata,
	output logic [oss_pkg::PDATA_W-1:0]   prdata,
	output logic                         pready
);
	import oss_pkg::*;

	cfg_t                  cfg_q;
	logic [2:0]            reg_idx;
	logic                  wr_en;
	logic [NUM_STAGES-1:0] vld_q;
	logic [NUM_STAGES-1:0] stage_en;
	pipe_ctl_t             ctl;

	logic                  accepted_s1;
	logic [EXP_W-1:0]      exp_s1;
	logic [FREQ_W-1:0]     osc_s1;
	res_meta_t             meta_s4;
	logic [FREQ_W-1:0]     diff_s4;

	// Configuration registers
	assign pready  = 1'b1;
	assign reg_idx = paddr[PADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.range_base <= RANGE_BASE_RST;
			cfg_q.freq_low   <= FREQ_LOW_RST;
			cfg_q.freq_high  <= FREQ_HIGH_RST;
			cfg_q.osc_low    <= OSC_LOW_RST;
			cfg_q.osc_high   <= OSC_HIGH_RST;
		end else if (wr_en) begin
			if (reg_idx == REG_RANGE_BASE) cfg_q.range_base <= pwdata[BASE_W-1:0];
			if (reg_idx == REG_FREQ_LOW)   cfg_q.freq_low   <= pwdata;
			if (reg_idx == REG_FREQ_HIGH)  cfg_q.freq_high  <= pwdata;
			if (reg_idx == REG_OSC_LOW)    cfg_q.osc_low    <= pwdata;
			if (reg_idx == REG_OSC_HIGH)   cfg_q.osc_high   <= pwdata;
		end
	end

	// Read back
	always_comb begin
		unique case (reg_idx)
			REG_RANGE_BASE: prdata = PDATA_W'(cfg_q.range_base);
			REG_FREQ_LOW:   prdata = cfg_q.freq_low;
			REG_FREQ_HIGH:  prdata = cfg_q.freq_high;
			REG_OSC_LOW:    prdata = cfg_q.osc_low;
			REG_OSC_HIGH:   prdata = cfg_q.osc_high;
			default:        prdata = '0;
		endcase
	end

	// Advance a stage when it is empty or the next one advances
	always_comb begin
		stage_en[NUM_STAGES-1] = !vld_q[NUM_STAGES-1] || out_ready;
		for (int k = NUM_STAGES - 2; k >= 0; k--) begin
			stage_en[k] = !vld_q[k] || stage_en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (stage_en[0]) vld_q[0] <= in_valid;
			for (int k = 1; k < NUM_STAGES; k++) begin
				if (stage_en[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	assign ctl.en    = stage_en;
	assign ctl.vld   = vld_q;
	assign in_ready  = stage_en[0];
	assign out_valid = vld_q[NUM_STAGES-1];

	oss_exp_stage u_exp (
		.clk         (clk),
		.ctl         (ctl),
		.cfg         (cfg_q),
		.target_freq (target_freq),
		.accepted_s1 (accepted_s1),
		.exp_s1      (exp_s1),
		.osc_s1      (osc_s1)
	);

	oss_range_pick u_range (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.range_base  (cfg_q.range_base),
		.accepted_s1 (accepted_s1),
		.exp_s1      (exp_s1),
		.osc_s1      (osc_s1),
		.meta_s4     (meta_s4),
		.diff_s4     (diff_s4)
	);

	oss_dac_div u_dac (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.meta_s4      (meta_s4),
		.diff_s4      (diff_s4),
		.accepted     (accepted),
		.prescale_exp (prescale_exp),
		.table_index  (table_index),
		.offset_code  (offset_code),
		.dac_code     (dac_code)
	);

	// An empty output stage leaves the whole pipe ready
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with an empty output stage");

	// Every transfer in lands in the first stage
	a_enter_stage1: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> vld_q[0])
		else $error("accepted request lost at stage one");

	// Accepted results stay within the exponent and table ranges
	a_result_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && accepted) |-> (prescale_exp <= EXP_W'(MAX_EXP)
			&& table_index <= IDX_W'(NUM_ENTRIES - 1)))
		else $error("result fields out of range");

	// Rejected results carry cleared settings
	a_reject_out: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !accepted) |-> (prescale_exp == '0 && table_index == '0
			&& offset_code == '0))
		else $error("rejected result carries settings");

endmodule

// ===== tb/oscillator_setting_solver_tb.sv =====
// Self-checking testbench for oscillator_setting_solver: sends frequency requests, writes
// the window and range registers over APB, predicts every setting and checks each result.
// Depends on oss_pkg and the oscillator_setting_solver RTL.
module oscillator_setting_solver_tb;
	import oss_pkg::*;

	localparam int unsigned CLK_HALF        = 4;
	localparam int unsigned RESET_CYCLES    = 6;
	localparam int unsigned STALL_LIMIT     = 4000;
	localparam int unsigned HOLD_OFF_CYCLES = 300;
	localparam int unsigned MAX_REPORTS     = 10;
	localparam int unsigned FLUSH_CYCLES    = NUM_STAGES + 4;
	localparam logic [2:0]  REG_SPARE       = 3'd5;

	// Oscillator bands: evenly spaced floors, each band twice the pitch wide
	localparam logic [FREQ_W-1:0] BAND_BASE     = 32'd30740000;
	localparam logic [FREQ_W-1:0] BAND_PITCH    = 32'd2560000;
	localparam logic [FREQ_W-1:0] BAND_SPAN     = 32'd5120000;
	localparam logic [FREQ_W-1:0] BAND_HALF     = 32'd2560000;
	localparam int unsigned       BAND_COUNT    = 13;
	localparam int unsigned       FALLBACK_BAND = 6;
	localparam logic [FREQ_W-1:0] ALL_ONES      = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [FREQ_W-1:0] request;
		logic              accepted;
		logic [EXP_W-1:0]  exp;
		logic [IDX_W-1:0]  idx;
		logic [OFS_W-1:0]  offset;
		logic [DAC_W-1:0]  dac;
	} setting_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [FREQ_W-1:0]   target_freq = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic                accepted;
	logic [EXP_W-1:0]    prescale_exp;
	logic [IDX_W-1:0]    table_index;
	logic [OFS_W-1:0]    offset_code;
	logic [DAC_W-1:0]    dac_code;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [PADDR_W-1:0]  paddr = '0;
	logic [PDATA_W-1:0]  pwdata = '0;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	// Register shadow used by the setting predictor
	logic [BASE_W-1:0]   cfg_range_base = 5'd0;
	logic [FREQ_W-1:0]   cfg_freq_low   = 32'd130000;
	logic [FREQ_W-1:0]   cfg_freq_high  = 32'd66600000;
	logic [FREQ_W-1:0]   cfg_osc_low    = 32'd33300000;
	logic [FREQ_W-1:0]   cfg_osc_high   = 32'd66600000;

	setting_t            pending_settings[$];
	int unsigned         error_count = 0;
	int unsigned         quiet_cycles = 0;
	int unsigned         send_idle_pct = 0;
	int unsigned         recv_idle_pct = 0;
	int unsigned         hold_requests = 0;
	int unsigned         holds_served = 0;
	int unsigned         hold_left = 0;

	oscillator_setting_solver i_dut (.*);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	function automatic logic [FREQ_W-1:0] band_floor(input int unsigned k);
		return BAND_BASE + FREQ_W'(k) * BAND_PITCH;
	endfunction

	// Work out the oscillator setting for one request under the current registers
	function automatic setting_t solve_setting(input logic [FREQ_W-1:0] f);
		setting_t          s;
		logic [FREQ_W-1:0] osc;
		logic [FREQ_W-1:0] lo;
		logic [FREQ_W-1:0] ctr;
		logic [FREQ_W-1:0] gap;
		logic [FREQ_W-1:0] best_dist;
		int unsigned       e;
		int unsigned       k;
		int unsigned       best;
		s = '0;
		s.request = f;
		if (f < cfg_freq_low || f > cfg_freq_high) begin
			return s;
		end
		// first exponent that lands strictly inside the window; on a miss osc keeps f << 8
		osc = f;
		for (e = 0; e < MAX_EXP; e++) begin
			osc = f << e;
			if (osc > cfg_osc_low && osc < cfg_osc_high) begin
				break;
			end
		end
		// closest centre among bands that hold osc, lower band on a tie
		best = FALLBACK_BAND;
		best_dist = ALL_ONES;
		for (k = 0; k < BAND_COUNT; k++) begin
			lo = band_floor(k);
			if (osc >= lo && osc <= lo + BAND_SPAN) begin
				ctr = lo + BAND_HALF;
				gap = (osc >= ctr) ? osc - ctr : ctr - osc;
				if (gap < best_dist) begin
					best_dist = gap;
					best = k;
				end
			end
		end
		s.accepted = 1'b1;
		s.exp = EXP_W'(e);
		s.idx = IDX_W'(best);
		s.offset = OFS_W'(cfg_range_base) + OFS_W'(best) - OFS_W'(FALLBACK_BAND);
		s.dac = DAC_W'((osc - band_floor(best)) / FREQ_W'(DAC_STEP));
		return s;
	endfunction

	function automatic logic [FREQ_W-1:0] random_freq();
		logic [FREQ_W-1:0] point;
		longint unsigned   span;
		case ($urandom_range(9))
			0: point = $urandom;
			1: point = cfg_freq_low + $urandom_range(2) - 1;
			2: point = cfg_freq_high + $urandom_range(2) - 1;
			3, 4: begin
				// land on a band edge, centre or midpoint between centres, then scale down
				point = band_floor($urandom_range(BAND_COUNT - 1))
					+ FREQ_W'($urandom_range(4)) * (BAND_SPAN / 4) + $urandom_range(2) - 1;
				point = point >> $urandom_range(MAX_EXP - 1);
			end
			default: begin
				if (cfg_freq_low <= cfg_freq_high) begin
					span = longint'(cfg_freq_high) - cfg_freq_low + 1;
					point = cfg_freq_low + FREQ_W'({$urandom, $urandom} % span);
				end else begin
					point = $urandom;
				end
			end
		endcase
		return point;
	endfunction

	task automatic report_error(input string msg);
		error_count++;
		if (error_count <= MAX_REPORTS) begin
			$display("ERROR at %0t: %s", $time, msg);
		end
	endtask

	// Offer one request after a random idle gap and hold it until the transfer
	task automatic send_request(input logic [FREQ_W-1:0] f);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		target_freq <= f;
		do @(posedge clk); while (!in_ready);
	endtask

	// Drop the request line and wait until every expected setting has come back
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_settings.size() != 0) begin
			@(posedge clk);
		end
		repeat (FLUSH_CYCLES) @(posedge clk);
	endtask

	// Write one register, then read it back where it exists
	task automatic write_reg(input logic [2:0] idx, input logic [PDATA_W-1:0] value);
		logic [PDATA_W-1:0] want;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		want = value;
		case (idx)
			REG_RANGE_BASE: begin
				cfg_range_base = value[BASE_W-1:0];
				want = PDATA_W'(value[BASE_W-1:0]);
			end
			REG_FREQ_LOW:  cfg_freq_low = value;
			REG_FREQ_HIGH: cfg_freq_high = value;
			REG_OSC_LOW:   cfg_osc_low = value;
			REG_OSC_HIGH:  cfg_osc_high = value;
			default: ;
		endcase
		if (idx <= REG_OSC_HIGH) begin
			penable <= 1'b0;
			pwrite <= 1'b0;
			@(posedge clk);
			penable <= 1'b1;
			@(posedge clk);
			if (prdata !== want) begin
				report_error($sformatf("register %0d read back %0h, expected %0h",
					idx, prdata, want));
			end
		end
		// return to idle between accesses
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_settings(input logic [PDATA_W-1:0] base, input logic [FREQ_W-1:0] flo,
			input logic [FREQ_W-1:0] fhi, input logic [FREQ_W-1:0] olo,
			input logic [FREQ_W-1:0] ohi);
		wait_drained();
		write_reg(REG_RANGE_BASE, base);
		write_reg(REG_FREQ_LOW, flo);
		write_reg(REG_FREQ_HIGH, fhi);
		write_reg(REG_OSC_LOW, olo);
		write_reg(REG_OSC_HIGH, ohi);
	endtask

	// Reset registers: both edges of the request window
	task automatic test_request_window();
		send_request(32'd129999);
		send_request(32'd130000);
		send_request(32'd66600000);
		send_request(32'd66600001);
	endtask

	task automatic test_exponent_search();
		int unsigned e;
		for (e = 0; e < MAX_EXP - 1 + 1; e++) begin
			send_request(32'd50000000 >> e);
		end
	endtask

	// Centre tie, one above a band centre, top band edge, and a value above every band
	task automatic test_band_selection();
		send_request(32'd34580000);
		send_request(32'd33300001);
		send_request(32'd66580000);
		send_request(32'd66590000);
	endtask

	// Shift wrap, fallback below the band floor, offset at both range_base extremes, wrapping at zero
	task automatic test_wrapping_cases();
		load_settings(31, 32'd0, ALL_ONES, 32'd33300000, 32'd66600000);
		send_request(32'd1);
		send_request(32'h8000_0001);
		send_request(32'h8000_0000 + 32'd25000000);
		send_request(32'd66580000);
		send_request(ALL_ONES);
		load_settings(0, 32'd0, ALL_ONES, 32'd0, ALL_ONES);
		send_request(32'd31000000);
		send_request(32'd0);
	endtask

	task automatic test_inverted_windows();
		load_settings(0, ALL_ONES, 32'd0, 32'd33300000, 32'd66600000);
		send_request(32'd0);
		send_request(32'd12345678);
		send_request(ALL_ONES);
		load_settings(17, 32'd0, ALL_ONES, ALL_ONES, 32'd0);
		send_request(32'd50000000);
	endtask

	// A write past the last register must leave every setting as it was
	task automatic test_spare_register();
		wait_drained();
		write_reg(REG_SPARE, $urandom);
		send_request(32'd40000000);
	endtask

	task automatic test_random_traffic(input int unsigned count, input int unsigned tx_pct,
			input int unsigned rx_pct);
		send_idle_pct = tx_pct;
		recv_idle_pct = rx_pct;
		repeat (count) send_request(random_freq());
		wait_drained();
	endtask

	// Stall the result side long enough to fill the pipeline, then drain it
	task automatic test_output_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_requests++;
		repeat (40) send_request(random_freq());
		wait_drained();
	endtask

	// Result side: random stalls plus long hold-offs on request
	always @(posedge clk) begin
		if (hold_requests != holds_served) begin
			holds_served = hold_requests;
			hold_left = HOLD_OFF_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Check each result transfer against the oldest prediction, then queue new ones
	always @(posedge clk) begin : watch_transfers
		setting_t got;
		setting_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got = '0;
				got.accepted = accepted;
				got.exp = prescale_exp;
				got.idx = table_index;
				got.offset = offset_code;
				got.dac = dac_code;
				if (pending_settings.size() == 0) begin
					report_error($sformatf("result with nothing pending: acc=%0d exp=%0d idx=%0d",
						got.accepted, got.exp, got.idx));
				end else begin
					want = pending_settings.pop_front();
					if (got.accepted !== want.accepted || got.exp !== want.exp
							|| got.idx !== want.idx || got.offset !== want.offset
							|| got.dac !== want.dac) begin
						report_error($sformatf(
							"freq %0d: expected acc=%0d exp=%0d idx=%0d ofs=%0d dac=%0d, got %s",
							want.request, want.accepted, want.exp, want.idx, want.offset,
							want.dac, $sformatf("acc=%0d exp=%0d idx=%0d ofs=%0d dac=%0d",
							got.accepted, got.exp, got.idx, got.offset, got.dac)));
					end
				end
			end
			if (in_valid && in_ready) begin
				pending_settings.push_back(solve_setting(target_freq));
			end
		end
	end

	// Abort when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || psel || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog: no transfer in %0d cycles", quiet_cycles);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		logic [FREQ_W-1:0] osc_floor;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_request_window();
		test_exponent_search();
		test_band_selection();
		test_wrapping_cases();
		test_inverted_windows();
		test_spare_register();

		load_settings(PDATA_W'(RANGE_BASE_RST), FREQ_LOW_RST, FREQ_HIGH_RST, OSC_LOW_RST,
			OSC_HIGH_RST);
		test_random_traffic(650, 13, 72);
		test_output_backpressure();

		osc_floor = $urandom_range(40000000, 20000000);
		load_settings($urandom_range(31), $urandom_range(2000000),
			$urandom_range(400000000, 40000000), osc_floor,
			osc_floor + $urandom_range(40000000, 1000));
		test_random_traffic(650, 72, 13);

		osc_floor = $urandom_range(40000000, 20000000);
		load_settings(31, 32'd0, ALL_ONES, osc_floor, osc_floor + $urandom_range(40000000, 1000));
		test_random_traffic(600, 0, 0);

		wait_drained();
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// ===== files.f =====
design/oss_pkg.sv
design/oss_exp_stage.sv
design/oss_range_pick.sv
design/oss_dac_div.sv
design/oscillator_setting_solver.sv
tb/oscillator_setting_solver_tb.sv
